### hdl/ciir_pkg.sv
`default_nettype none

package ciir_pkg;

	// fixed formats of the contact word
	localparam int NORM_FRAC  = 14;        // Q1.14 normals
	localparam int DIST_SHIFT = 16;        // distance is scaled by 2^16 before the step divide
	localparam logic [15:0] STEP_RESET = 16'd1092;

	// saturate a wide signed value to 32 bits
	function automatic logic [31:0] sat32(input logic signed [63:0] x);
		logic [31:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/ciir_div.sv
`default_nettype none

// restoring divider, one quotient bit per stage, all stages advance on en
module ciir_div #(
	parameter int NUM_W  = 48,
	parameter int DEN_W  = 16,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [NUM_W-1:0]  in_num,
	input  wire logic [DEN_W-1:0]  in_den,
	input  wire logic              in_neg,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [NUM_W-1:0]       out_quo,
	output logic                   out_neg,
	output logic [SIDE_W-1:0]      out_side
);
	import ciir_pkg::*;

	logic              v_s    [0:NUM_W];
	logic [DEN_W-1:0]  rem_s  [0:NUM_W];
	logic [NUM_W-1:0]  num_s  [0:NUM_W];
	logic [NUM_W-1:0]  quo_s  [0:NUM_W];
	logic [DEN_W-1:0]  den_s  [0:NUM_W];
	logic              neg_s  [0:NUM_W];
	logic [SIDE_W-1:0] side_s [0:NUM_W];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign num_s[0]  = in_num;
	assign quo_s[0]  = '0;
	assign den_s[0]  = in_den;
	assign neg_s[0]  = in_neg;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;
		logic [DEN_W-1:0] nrem;

		always_comb begin
			trial = {rem_s[i], num_s[i][NUM_W-1]};
			diff  = trial - {1'b0, den_s[i]};
			ge    = (trial >= {1'b0, den_s[i]});
			nrem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= nrem;
				num_s[i+1]  <= {num_s[i][NUM_W-2:0], 1'b0};
				quo_s[i+1]  <= {quo_s[i][NUM_W-2:0], ge};
				den_s[i+1]  <= den_s[i];
				neg_s[i+1]  <= neg_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[NUM_W];
	assign out_quo   = quo_s[NUM_W];
	assign out_neg   = neg_s[NUM_W];
	assign out_side  = side_s[NUM_W];

endmodule

`default_nettype wire

### hdl/contact_impulse_resolver.sv
// Pipeline: 3 dot-product stages, 48-stage distance/step divider, 2 removal stages,
//   57-stage impulse divider, 4 push stages.
// Throughput: one contact word per cycle; the whole pipeline holds while a result
//   word waits at the output, so in_ready = !out_valid || out_ready.
// Reset: arst_n clears all valid bits and loads step_seconds with 1092; data
//   registers are not reset.
`default_nettype none

module contact_impulse_resolver #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: step_seconds
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	// contact word in
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] normal_x,
	input  wire logic [15:0] normal_y,
	input  wire logic [31:0] contact_distance,
	input  wire logic [31:0] vel_a_x,
	input  wire logic [31:0] vel_a_y,
	input  wire logic [31:0] vel_b_x,
	input  wire logic [31:0] vel_b_y,
	input  wire logic [23:0] inv_mass_a,
	input  wire logic [23:0] inv_mass_b,
	input  wire logic [23:0] push_gain_a,
	input  wire logic [23:0] push_gain_b,
	// result word out
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      impulse,
	output logic             hit,
	output logic [31:0]      delta_a_x,
	output logic [31:0]      delta_a_y,
	output logic [31:0]      delta_b_x,
	output logic [31:0]      delta_b_y
);
	import ciir_pkg::*;

	// mass sum: either ma+mb (25 bits) or 2.0 in Q.F
	localparam int SUM_W   = (FRAC_BITS + 2 > 25) ? FRAC_BITS + 2 : 25;
	localparam int DNUM_W  = 32 + DIST_SHIFT;      // |distance| * 2^16
	localparam int INUM_W  = 57;                   // clamped removal * 2^F, at most 2^56
	localparam int SIDE1_W = 36 + 16 + 16 + 24 + 24 + SUM_W;
	localparam int SIDE2_W = 16 + 16 + 24 + 24;
	localparam int PF_W    = 59 - FRAC_BITS;       // push after the Q.F floor
	localparam logic [INUM_W-1:0] LIMIT = INUM_W'(1) << (56 - FRAC_BITS);

	logic en;

	// step register; a zero step divides as 1
	logic [15:0] step_q;
	logic [15:0] step_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	assign step_div = (step_q == 16'd0) ? 16'd1 : step_q;

	// whole pipeline advances unless a result word is held at the output
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// ---------------------------------------------------------------- s1
	// relative velocity b - a and mass sum
	logic               v_s1;
	logic signed [32:0] dvx_s1, dvy_s1;
	logic signed [15:0] nx_s1, ny_s1;
	logic [31:0]        dist_s1;
	logic [23:0]        ga_s1, gb_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [SUM_W-1:0]   sum_c;

	always_comb begin
		if (inv_mass_a == 24'd0 && inv_mass_b == 24'd0) begin
			sum_c = SUM_W'(2) << FRAC_BITS;
		end else begin
			sum_c = SUM_W'(inv_mass_a) + SUM_W'(inv_mass_b);
		end
	end

	// ---------------------------------------------------------------- s2
	// projection products, Q.(F+14)
	logic               v_s2;
	logic signed [48:0] px_s2, py_s2;
	logic signed [15:0] nx_s2, ny_s2;
	logic [31:0]        dist_s2;
	logic [23:0]        ga_s2, gb_s2;
	logic [SUM_W-1:0]   sum_s2;

	// ---------------------------------------------------------------- s3
	// floored dot product and distance magnitude for the step divide
	logic               v_s3;
	logic [35:0]        fdot_s3;
	logic [DNUM_W-1:0]  dnum_s3;
	logic               dneg_s3;
	logic signed [15:0] nx_s3, ny_s3;
	logic [23:0]        ga_s3, gb_s3;
	logic [SUM_W-1:0]   sum_s3;

	logic [49:0] dot_c;
	logic [31:0] dmag_c;

	assign dot_c  = {px_s2[48], px_s2} + {py_s2[48], py_s2};
	assign dmag_c = dist_s2[31] ? (32'd0 - dist_s2) : dist_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvx_s1  <= $signed({vel_b_x[31], vel_b_x}) - $signed({vel_a_x[31], vel_a_x});
			dvy_s1  <= $signed({vel_b_y[31], vel_b_y}) - $signed({vel_a_y[31], vel_a_y});
			nx_s1   <= $signed(normal_x);
			ny_s1   <= $signed(normal_y);
			dist_s1 <= contact_distance;
			ga_s1   <= push_gain_a;
			gb_s1   <= push_gain_b;
			sum_s1  <= sum_c;

			px_s2   <= dvx_s1 * nx_s1;
			py_s2   <= dvy_s1 * ny_s1;
			nx_s2   <= nx_s1;
			ny_s2   <= ny_s1;
			dist_s2 <= dist_s1;
			ga_s2   <= ga_s1;
			gb_s2   <= gb_s1;
			sum_s2  <= sum_s1;

			fdot_s3 <= dot_c[49:NORM_FRAC];
			dnum_s3 <= {dmag_c, {DIST_SHIFT{1'b0}}};
			dneg_s3 <= dist_s2[31];
			nx_s3   <= nx_s2;
			ny_s3   <= ny_s2;
			ga_s3   <= ga_s2;
			gb_s3   <= gb_s2;
			sum_s3  <= sum_s2;
		end
	end

	// ---------------------------------------------------------------- distance / step
	logic               dv_v;
	logic [DNUM_W-1:0]  dq;
	logic               dq_neg;
	logic [SIDE1_W-1:0] side1_out;

	ciir_div #(
		.NUM_W (DNUM_W),
		.DEN_W (16),
		.SIDE_W(SIDE1_W)
	) u_div_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_num   (dnum_s3),
		.in_den   (step_div),
		.in_neg   (dneg_s3),
		.in_side  ({fdot_s3, nx_s3, ny_s3, ga_s3, gb_s3, sum_s3}),
		.out_valid(dv_v),
		.out_quo  (dq),
		.out_neg  (dq_neg),
		.out_side (side1_out)
	);

	logic [35:0]      d_fdot;
	logic [15:0]      d_nx, d_ny;
	logic [23:0]      d_ga, d_gb;
	logic [SUM_W-1:0] d_sum;

	assign {d_fdot, d_nx, d_ny, d_ga, d_gb, d_sum} = side1_out;

	// ---------------------------------------------------------------- r1
	// removal = floored dot + signed distance term (truncated toward zero)
	logic             v_r1_s1;
	logic [50:0]      rem_r1_s1;
	logic [15:0]      nx_r1_s1, ny_r1_s1;
	logic [23:0]      ga_r1_s1, gb_r1_s1;
	logic [SUM_W-1:0] sum_r1_s1;

	logic [DNUM_W:0] dqs_c;
	assign dqs_c = dq_neg ? ((DNUM_W + 1)'(0) - {1'b0, dq}) : {1'b0, dq};

	// ---------------------------------------------------------------- r2
	// only a negative removal makes an impulse; huge ones are limited first
	logic             v_r2_s2;
	logic [INUM_W-1:0] inum_r2_s2;
	logic [15:0]      nx_r2_s2, ny_r2_s2;
	logic [23:0]      ga_r2_s2, gb_r2_s2;
	logic [SUM_W-1:0] sum_r2_s2;

	logic [50:0]       nrem_c;
	logic [INUM_W-1:0] nmag_c;
	logic [INUM_W-1:0] clamp_c;

	always_comb begin
		nrem_c  = 51'd0 - rem_r1_s1;
		nmag_c  = INUM_W'(nrem_c);
		clamp_c = (nmag_c > LIMIT) ? LIMIT : nmag_c;
		if (!rem_r1_s1[50]) begin
			clamp_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1_s1 <= 1'b0;
			v_r2_s2 <= 1'b0;
		end else if (en) begin
			v_r1_s1 <= dv_v;
			v_r2_s2 <= v_r1_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_r1_s1  <= {{15{d_fdot[35]}}, d_fdot} + {{(50 - DNUM_W){dqs_c[DNUM_W]}}, dqs_c};
			nx_r1_s1   <= d_nx;
			ny_r1_s1   <= d_ny;
			ga_r1_s1   <= d_ga;
			gb_r1_s1   <= d_gb;
			sum_r1_s1  <= d_sum;

			inum_r2_s2 <= clamp_c << FRAC_BITS;
			nx_r2_s2   <= nx_r1_s1;
			ny_r2_s2   <= ny_r1_s1;
			ga_r2_s2   <= ga_r1_s1;
			gb_r2_s2   <= gb_r1_s1;
			sum_r2_s2  <= sum_r1_s1;
		end
	end

	// ---------------------------------------------------------------- removal / mass sum
	logic               iv_v;
	logic [INUM_W-1:0]  iq;
	logic               iq_neg;
	logic [SIDE2_W-1:0] side2_out;

	ciir_div #(
		.NUM_W (INUM_W),
		.DEN_W (SUM_W),
		.SIDE_W(SIDE2_W)
	) u_div_imp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_r2_s2),
		.in_num   (inum_r2_s2),
		.in_den   (sum_r2_s2),
		.in_neg   (1'b1),
		.in_side  ({nx_r2_s2, ny_r2_s2, ga_r2_s2, gb_r2_s2}),
		.out_valid(iv_v),
		.out_quo  (iq),
		.out_neg  (iq_neg),
		.out_side (side2_out)
	);

	logic [15:0] i_nx, i_ny;
	logic [23:0] i_ga, i_gb;

	assign {i_nx, i_ny, i_ga, i_gb} = side2_out;

	// ---------------------------------------------------------------- p1
	// impulse = -quotient, saturated at -2^31
	logic               v_p1_s1;
	logic signed [31:0] imp_p1_s1;
	logic               hit_p1_s1;
	logic signed [15:0] nx_p1_s1, ny_p1_s1;
	logic [23:0]        ga_p1_s1, gb_p1_s1;

	logic [31:0] imp_c;
	always_comb begin
		if (iq[INUM_W-1:31] != '0) begin
			imp_c = 32'h8000_0000;
		end else if (iq_neg) begin
			imp_c = 32'd0 - iq[31:0];
		end else begin
			imp_c = iq[31:0];
		end
	end

	// ---------------------------------------------------------------- p2
	// impulse * normal, floored to Q.F
	logic               v_p2_s2;
	logic signed [31:0] imp_p2_s2;
	logic               hit_p2_s2;
	logic signed [47:0] ix_c, iy_c;
	logic signed [33:0] tx_p2_s2, ty_p2_s2;
	logic [23:0]        ga_p2_s2, gb_p2_s2;

	assign ix_c = imp_p1_s1 * nx_p1_s1;
	assign iy_c = imp_p1_s1 * ny_p1_s1;

	// ---------------------------------------------------------------- p3
	// times gain
	logic               v_p3_s3;
	logic [31:0]        imp_p3_s3;
	logic               hit_p3_s3;
	logic signed [58:0] ax_p3_s3, ay_p3_s3, bx_p3_s3, by_p3_s3;

	// ---------------------------------------------------------------- p4
	// floor to Q.F and saturate; body b takes the negated push
	logic [PF_W-1:0] fax_c, fay_c, fbx_c, fby_c;
	logic [63:0]     eax_c, eay_c, ebx_c, eby_c;

	always_comb begin
		fax_c = ax_p3_s3[58:FRAC_BITS];
		fay_c = ay_p3_s3[58:FRAC_BITS];
		fbx_c = bx_p3_s3[58:FRAC_BITS];
		fby_c = by_p3_s3[58:FRAC_BITS];
		eax_c = {{(64 - PF_W){fax_c[PF_W-1]}}, fax_c};
		eay_c = {{(64 - PF_W){fay_c[PF_W-1]}}, fay_c};
		ebx_c = 64'd0 - {{(64 - PF_W){fbx_c[PF_W-1]}}, fbx_c};
		eby_c = 64'd0 - {{(64 - PF_W){fby_c[PF_W-1]}}, fby_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1_s1   <= 1'b0;
			v_p2_s2   <= 1'b0;
			v_p3_s3   <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_p1_s1   <= iv_v;
			v_p2_s2   <= v_p1_s1;
			v_p3_s3   <= v_p2_s2;
			out_valid <= v_p3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			imp_p1_s1 <= $signed(imp_c);
			hit_p1_s1 <= (iq != '0);
			nx_p1_s1  <= $signed(i_nx);
			ny_p1_s1  <= $signed(i_ny);
			ga_p1_s1  <= i_ga;
			gb_p1_s1  <= i_gb;

			imp_p2_s2 <= imp_p1_s1;
			hit_p2_s2 <= hit_p1_s1;
			tx_p2_s2  <= ix_c[47:NORM_FRAC];
			ty_p2_s2  <= iy_c[47:NORM_FRAC];
			ga_p2_s2  <= ga_p1_s1;
			gb_p2_s2  <= gb_p1_s1;

			imp_p3_s3 <= imp_p2_s2;
			hit_p3_s3 <= hit_p2_s2;
			ax_p3_s3  <= tx_p2_s2 * $signed({1'b0, ga_p2_s2});
			ay_p3_s3  <= ty_p2_s2 * $signed({1'b0, ga_p2_s2});
			bx_p3_s3  <= tx_p2_s2 * $signed({1'b0, gb_p2_s2});
			by_p3_s3  <= ty_p2_s2 * $signed({1'b0, gb_p2_s2});

			impulse   <= imp_p3_s3;
			hit       <= hit_p3_s3;
			delta_a_x <= sat32(eax_c);
			delta_a_y <= sat32(eay_c);
			delta_b_x <= sat32(ebx_c);
			delta_b_y <= sat32(eby_c);
		end
	end

endmodule

`default_nettype wire

### hdl/ciir_checker.sv
`default_nettype none

module ciir_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] impulse,
	input wire logic        hit,
	input wire logic [31:0] delta_a_x,
	input wire logic [31:0] delta_a_y,
	input wire logic [31:0] delta_b_x,
	input wire logic [31:0] delta_b_y
);
	import ciir_pkg::*;

	// held word stays up
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(impulse))
		else $error("result word dropped or changed while held");

	// impulse never positive, hit marks a non-zero one
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (impulse != 32'd0)) && (hit == impulse[31]))
		else $error("hit flag does not match impulse");

	// no impulse, no push
	a_nopush: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> delta_a_x == 32'd0 && delta_a_y == 32'd0 &&
			delta_b_x == 32'd0 && delta_b_y == 32'd0)
		else $error("velocity change without impulse");

	// nothing comes out straight after reset
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result word right after reset");

endmodule

bind contact_impulse_resolver ciir_checker u_ciir_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.impulse  (impulse),
	.hit      (hit),
	.delta_a_x(delta_a_x),
	.delta_a_y(delta_a_y),
	.delta_b_x(delta_b_x),
	.delta_b_y(delta_b_y)
);

`default_nettype wire

### dv/tb.sv
`default_nettype none

module tb;
	import ciir_pkg::*;

	// contact word as driven onto the input ports
	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [31:0] sep;
		logic [31:0] vax;
		logic [31:0] vay;
		logic [31:0] vbx;
		logic [31:0] vby;
		logic [23:0] ma;
		logic [23:0] mb;
		logic [23:0] ga;
		logic [23:0] gb;
	} contact_t;

	// result word
	typedef struct packed {
		logic [31:0] imp;
		logic        hit;
		logic [31:0] dax;
		logic [31:0] day;
		logic [31:0] dbx;
		logic [31:0] dby;
	} resolve_t;

	localparam int FB = 16;
	localparam int LATENCY = 114;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	contact_t drv_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	wire resolve_t got;

	contact_t pending_q[$];     // words waiting for the driver
	resolve_t expected_q[$];    // predicted results, oldest first
	logic [15:0] step_cur;      // predictor's copy of step_seconds
	int send_idle_pct = 6;
	int recv_idle_pct = 57;
	int errors = 0;
	longint cycles = 0;

	always #1 clk = ~clk;

	contact_impulse_resolver #(.FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.normal_x(drv_word.nx), .normal_y(drv_word.ny),
		.contact_distance(drv_word.sep),
		.vel_a_x(drv_word.vax), .vel_a_y(drv_word.vay),
		.vel_b_x(drv_word.vbx), .vel_b_y(drv_word.vby),
		.inv_mass_a(drv_word.ma), .inv_mass_b(drv_word.mb),
		.push_gain_a(drv_word.ga), .push_gain_b(drv_word.gb),
		.out_valid(out_valid), .out_ready(out_ready),
		.impulse(got.imp), .hit(got.hit),
		.delta_a_x(got.dax), .delta_a_y(got.day),
		.delta_b_x(got.dbx), .delta_b_y(got.dby)
	);

	// floor division by 2^k of a signed value
	function automatic logic signed [127:0] floor_sh(input logic signed [127:0] x, input int k);
		return x >>> k;
	endfunction

	function automatic logic signed [127:0] clip32(input logic signed [127:0] x);
		if (x > 128'sd2147483647)
			return 128'sd2147483647;
		if (x < -128'sd2147483648)
			return -128'sd2147483648;
		return x;
	endfunction

	function automatic logic signed [127:0] gain_push(input logic signed [127:0] imp,
			input logic [15:0] n, input logic [23:0] g);
		logic signed [127:0] t;
		t = floor_sh(imp * $signed({{112{n[15]}}, n}), NORM_FRAC);
		return floor_sh(t * $signed({104'd0, g}), FB);
	endfunction

	// predicted resolution of one contact under the current step
	function automatic resolve_t resolve_contact(input contact_t c, input logic [15:0] st);
		logic signed [127:0] nx, ny, dot, rem, sum, imp, step, dterm, lim;
		logic signed [127:0] pax, pay, pbx, pby;
		resolve_t r;
		nx = $signed({{112{c.nx[15]}}, c.nx});
		ny = $signed({{112{c.ny[15]}}, c.ny});
		step = (st == 16'd0) ? 128'sd1 : $signed({112'd0, st});
		dot = ($signed({{96{c.vbx[31]}}, c.vbx}) - $signed({{96{c.vax[31]}}, c.vax})) * nx
			+ ($signed({{96{c.vby[31]}}, c.vby}) - $signed({{96{c.vay[31]}}, c.vay})) * ny;
		// distance term truncates toward zero; SV signed divide does too
		dterm = ($signed({{96{c.sep[31]}}, c.sep}) * 128'sd65536) / step;
		rem = floor_sh(dot, NORM_FRAC) + dterm;
		if (c.ma == 0 && c.mb == 0)
			sum = 128'sd2 <<< FB;
		else
			sum = $signed({104'd0, c.ma}) + $signed({104'd0, c.mb});
		lim = 128'sd1 <<< (56 - FB);
		if (rem >= 0) begin
			imp = 0;
		end else begin
			// very large removal is limited before the divide
			if (rem < -lim)
				rem = -lim;
			imp = clip32((rem <<< FB) / sum);
		end
		pax = clip32(gain_push(imp, c.nx, c.ga));
		pay = clip32(gain_push(imp, c.ny, c.ga));
		pbx = clip32(-gain_push(imp, c.nx, c.gb));
		pby = clip32(-gain_push(imp, c.ny, c.gb));
		r.imp = imp[31:0];
		r.hit = (imp < 0);
		r.dax = pax[31:0];
		r.day = pay[31:0];
		r.dbx = pbx[31:0];
		r.dby = pby[31:0];
		return r;
	endfunction

	function automatic logic [31:0] rnd32_edge();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 255) - 128;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [23:0] rnd24_edge();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFF_FFFF;
			2: return 24'd1 << $urandom_range(8, 20);
			default: return 24'($urandom);
		endcase
	endfunction

	// mostly unit-like normals, some raw patterns
	function automatic contact_t rnd_contact();
		contact_t c;
		if ($urandom_range(0, 3) != 0) begin
			c.nx = 16'($urandom_range(0, 32768) - 16384);
			c.ny = 16'($urandom_range(0, 32768) - 16384);
		end else begin
			c.nx = 16'($urandom);
			c.ny = 16'($urandom);
		end
		c.sep = ($urandom_range(0, 2) == 0) ? rnd32_edge()
			: 32'($signed($urandom_range(0, 131072)) - 65536);
		c.vax = rnd32_edge();
		c.vay = rnd32_edge();
		c.vbx = rnd32_edge();
		c.vby = rnd32_edge();
		c.ma = rnd24_edge();
		c.mb = rnd24_edge();
		c.ga = rnd24_edge();
		c.gb = rnd24_edge();
		return c;
	endfunction

	// driver: pops pending words, holds valid until accepted
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!in_valid || in_ready) begin
			if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				drv_word <= pending_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// prediction at acceptance, so config writes between phases are seen
	always @(posedge clk) begin
		if (in_valid && in_ready)
			expected_q = {expected_q, resolve_contact(drv_word, step_cur)};
	end

	// monitor: compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		resolve_t e;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				errors = errors + 1;
			end else begin
				e = expected_q.pop_front();
				if (got.imp !== e.imp) begin
					$error("impulse exp %h got %h", e.imp, got.imp); errors = errors + 1;
				end
				if (got.hit !== e.hit) begin
					$error("hit exp %b got %b", e.hit, got.hit); errors = errors + 1;
				end
				if (got.dax !== e.dax) begin
					$error("delta_a_x exp %h got %h", e.dax, got.dax); errors = errors + 1;
				end
				if (got.day !== e.day) begin
					$error("delta_a_y exp %h got %h", e.day, got.day); errors = errors + 1;
				end
				if (got.dbx !== e.dbx) begin
					$error("delta_b_x exp %h got %h", e.dbx, got.dbx); errors = errors + 1;
				end
				if (got.dby !== e.dby) begin
					$error("delta_b_y exp %h got %h", e.dby, got.dby); errors = errors + 1;
				end
			end
		end
	end

	// timeout guard
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// wait for the pipeline to empty out
	task automatic drain();
		while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_step(input logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		step_cur <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_random(input int n);
		repeat (n) pending_q = {pending_q, rnd_contact()};
	endtask

	initial begin
		contact_t c;
		step_cur = STEP_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset step value first
		c = '0;
		pending_q = {pending_q, c};                   // all zero, no hit
		c.nx = 16'sd16384; c.vax = 32'sd65536; c.ma = 24'd65536; c.mb = 24'd65536;
		c.ga = 24'd65536; c.gb = 24'd65536;
		pending_q = {pending_q, c};                   // plain approaching contact
		c.ma = 24'd0; c.mb = 24'd0;
		pending_q = {pending_q, c};                   // both immovable, divisor of two
		c.nx = 16'h8000; c.ny = 16'h7FFF;             // raw non-unit normal
		c.vax = 32'h7FFF_FFFF; c.vay = 32'h8000_0000;
		c.vbx = 32'h8000_0000; c.vby = 32'h7FFF_FFFF;
		pending_q = {pending_q, c};
		c.ma = 24'd1; c.ga = 24'hFF_FFFF; c.gb = 24'hFF_FFFF;
		pending_q = {pending_q, c};                   // huge separating speed, no hit
		c = '0; c.sep = 32'h8000_0000; c.ma = 24'hFF_FFFF; c.mb = 24'hFF_FFFF;
		c.nx = 16'hC000; c.ny = 16'h4000; c.ga = 24'd100; c.gb = 24'hFF_FFFF;
		pending_q = {pending_q, c};                   // deep penetration
		c.sep = 32'h7FFF_FFFF;
		pending_q = {pending_q, c};                   // separating, no hit
		drain();

		// zero step acts as one
		write_step(16'd0);
		c = '0; c.sep = 32'hFFFF_FFFF; c.ma = 24'd1; c.nx = 16'sd16384; c.ga = 24'd65536;
		pending_q = {pending_q, c};
		fill_random(4);
		drain();
		write_step(16'hFFFF);
		fill_random(6);
		drain();

		// random phases: sender light, receiver heavy
		send_idle_pct = 6; recv_idle_pct = 57;
		write_step(16'd1);
		fill_random(300);
		drain();
		write_step(16'($urandom));
		fill_random(300);
		// hold the sender until every result is in
		drain();

		// then the other way round
		send_idle_pct = 57; recv_idle_pct = 6;
		write_step(STEP_RESET);
		fill_random(350);
		drain();
		write_step(16'hFFFF);
		fill_random(350);
		drain();

		// no idling on either side
		send_idle_pct = 0; recv_idle_pct = 0;
		write_step(16'($urandom));
		fill_random(700);
		drain();

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
